// ----- rtl/bps_pkg.sv -----
// Package for the bilinear pixel sampler: field widths, register indexes,
// operation codes and the bank-select struct shared by the sampler modules.
// No dependencies.
package bps_pkg;

  localparam int PIX_W    = 8;   // grayscale pixel and sample width
  localparam int COORD_W  = 8;   // write column / row width
  localparam int PROBE_W  = 18;  // signed probe coordinate width
  localparam int CFG_W    = 9;   // widest configuration register
  localparam int CFG_IDX_W = 1;  // configuration register index width

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PROBE = 1'b1;

  // Bank of each neighbour: {row parity, column parity}
  typedef struct packed {
    logic [1:0] tl;
    logic [1:0] tr;
    logic [1:0] bl;
    logic [1:0] br;
  } bank_sel_t;

endpackage

// ----- rtl/bps_if.sv -----
// Channel interfaces of the bilinear pixel sampler: input items and results.
// Depends on bps_pkg.
interface bps_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  operation;
  logic [bps_pkg::COORD_W-1:0]           write_column;
  logic [bps_pkg::COORD_W-1:0]           write_row;
  logic [bps_pkg::PIX_W-1:0]             write_value;
  logic signed [bps_pkg::PROBE_W-1:0]    probe_x;
  logic signed [bps_pkg::PROBE_W-1:0]    probe_y;

  modport source (output valid, operation, write_column, write_row, write_value,
                  probe_x, probe_y, input ready);
  modport sink   (input valid, operation, write_column, write_row, write_value,
                  probe_x, probe_y, output ready);
endinterface

interface bps_out_if;
  logic                        valid;
  logic                        ready;
  logic [bps_pkg::PIX_W-1:0]   sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

// ----- rtl/bps_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bps_addr_gen.sv -----
// Probe address generation: floor, clamp and map the four neighbours onto the
// four parity banks of the image store. Depends on bps_pkg.
module bps_addr_gen #(
  parameter int FRAC_BITS = 8,
  parameter int CW        = 8,   // column index width
  parameter int RW        = 8,   // row index width
  parameter int AW        = 14   // bank address width
) (
  input  logic signed [bps_pkg::PROBE_W-1:0] probe_x,
  input  logic signed [bps_pkg::PROBE_W-1:0] probe_y,
  input  logic [CW-1:0]                      col_last,
  input  logic [RW-1:0]                      row_last,
  output logic [AW-1:0]                      rd_addr [4],
  output bps_pkg::bank_sel_t                 sel,
  output logic [FRAC_BITS-1:0]               wr,
  output logic [FRAC_BITS-1:0]               wb
);

  localparam int LW  = bps_pkg::PROBE_W - FRAC_BITS;
  localparam int BCW = (CW > 1) ? CW - 1 : 1;
  localparam int BRW = (RW > 1) ? RW - 1 : 1;

  logic signed [LW-1:0] left, top;
  logic [CW-1:0] c0, c1, col_k;
  logic [RW-1:0] r0, r1, row_k;

  // Clamp left/top (+ offset) into [0, last]
  function automatic int clamp_idx(input logic signed [LW-1:0] v, input int add,
                                   input int last);
    int s;
    s = int'(v) + add;
    if (s < 0) begin
      return 0;
    end else if (s > last) begin
      return last;
    end
    return s;
  endfunction

  assign wr   = probe_x[FRAC_BITS-1:0];
  assign wb   = probe_y[FRAC_BITS-1:0];
  assign left = probe_x[bps_pkg::PROBE_W-1:FRAC_BITS];
  assign top  = probe_y[bps_pkg::PROBE_W-1:FRAC_BITS];

  assign c0 = CW'(clamp_idx(left, 0, int'(col_last)));
  assign c1 = CW'(clamp_idx(left, 1, int'(col_last)));
  assign r0 = RW'(clamp_idx(top, 0, int'(row_last)));
  assign r1 = RW'(clamp_idx(top, 1, int'(row_last)));

  assign sel.tl = {r0[0], c0[0]};
  assign sel.tr = {r0[0], c1[0]};
  assign sel.bl = {r1[0], c0[0]};
  assign sel.br = {r1[0], c1[0]};

  // Each bank serves the neighbour column/row of its own parity
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      col_k = (c0[0] == k[0]) ? c0 : c1;
      row_k = (r0[0] == k[1]) ? r0 : r1;
      rd_addr[k] = {BRW'(row_k >> 1), BCW'(col_k >> 1)};
    end
  end

endmodule

// ----- rtl/bps_interp.sv -----
// Interpolation pipeline: bank data select and horizontal blend, vertical
// blend with rounding, output register. Depends on bps_pkg.
module bps_interp #(
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          probe_fire,
  input  bps_pkg::bank_sel_t            sel,
  input  logic [FRAC_BITS-1:0]          wr,
  input  logic [FRAC_BITS-1:0]          wb,
  input  logic [bps_pkg::PIX_W-1:0]     bank_data [4],
  output logic                          in_ready,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [bps_pkg::PIX_W-1:0]     out_sample
);

  localparam int PW = bps_pkg::PIX_W;
  localparam int HW = PW + FRAC_BITS;       // horizontal blend width
  localparam int SW = PW + 2 * FRAC_BITS;   // full weighted sum width
  localparam logic [FRAC_BITS:0] SCALE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic                   valid_b_r, valid_b_nxt;
  bps_pkg::bank_sel_t     sel_b_r;
  logic [FRAC_BITS-1:0]   wr_b_r, wb_b_r;
  logic                   valid_c_r, valid_c_nxt;
  logic [HW-1:0]          top_h_r, bot_h_r, top_h_nxt, bot_h_nxt;
  logic [FRAC_BITS-1:0]   wb_c_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [PW-1:0]          out_sample_r, out_sample_nxt;
  logic                   ready_b, ready_c, ready_d;
  logic [PW-1:0]          p_tl, p_tr, p_bl, p_br;
  logic [FRAC_BITS:0]     wl, wt;
  logic [HW:0]            top_sum, bot_sum;
  logic [SW:0]            v_sum;

  assign ready_d  = !out_valid_r || out_ready;
  assign ready_c  = !valid_c_r || ready_d;
  assign ready_b  = !valid_b_r || ready_c;
  assign in_ready = ready_b;

  // Stage B: pick neighbours from the banks and blend horizontally
  assign p_tl = bank_data[sel_b_r.tl];
  assign p_tr = bank_data[sel_b_r.tr];
  assign p_bl = bank_data[sel_b_r.bl];
  assign p_br = bank_data[sel_b_r.br];
  assign wl   = SCALE - (FRAC_BITS+1)'(wr_b_r);

  assign top_sum = (HW+1)'(p_tl) * (HW+1)'(wl) + (HW+1)'(p_tr) * (HW+1)'(wr_b_r);
  assign bot_sum = (HW+1)'(p_bl) * (HW+1)'(wl) + (HW+1)'(p_br) * (HW+1)'(wr_b_r);
  assign top_h_nxt = top_sum[HW-1:0];
  assign bot_h_nxt = bot_sum[HW-1:0];

  // Stage C: vertical blend, round half up
  assign wt    = SCALE - (FRAC_BITS+1)'(wb_c_r);
  assign v_sum = (SW+1)'(top_h_r) * (SW+1)'(wt) + (SW+1)'(bot_h_r) * (SW+1)'(wb_c_r)
               + ((SW+1)'(1) << (2 * FRAC_BITS - 1));
  assign out_sample_nxt = v_sum[SW-1:2*FRAC_BITS];

  assign valid_b_nxt   = ready_b ? probe_fire : valid_b_r;
  assign valid_c_nxt   = ready_c ? valid_b_r : valid_c_r;
  assign out_valid_nxt = ready_d ? valid_c_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r   <= 1'b0;
      valid_c_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_b_r   <= valid_b_nxt;
      valid_c_r   <= valid_c_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b) begin
      sel_b_r <= sel;
      wr_b_r  <= wr;
      wb_b_r  <= wb;
    end
    if (ready_c) begin
      top_h_r <= top_h_nxt;
      bot_h_r <= bot_h_nxt;
      wb_c_r  <= wb_b_r;
    end
    if (ready_d) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  a_probe_enters: assert property (@(posedge clk) disable iff (!rst_n)
    probe_fire |=> valid_b_r)
    else $error("accepted probe did not reach the blend stage");

  a_b_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_b_r && !ready_c) |=> (valid_b_r && $stable(sel_b_r) && $stable(wr_b_r)))
    else $error("stalled blend stage lost its probe");

  a_c_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_c_r && !ready_d) |=> (valid_c_r && $stable(top_h_r) && $stable(bot_h_r)))
    else $error("stalled vertical stage changed its operands");

endmodule

// ----- rtl/bilinear_pixel_sampler.sv -----
// Top level of the bilinear pixel sampler: configuration registers, four-bank
// image store and the probe pipeline. Depends on bps_pkg, bps_if, bps_ram,
// bps_addr_gen and bps_interp.
//
//   channel  | dir | handshake          | carries
//   ---------+-----+--------------------+---------------------------------------
//   in_ch    | in  | valid/ready        | operation, write pixel, probe x/y
//   out_ch   | out | valid/ready        | sample (one per probe, none per write)
//   cfg_*    | in  | cfg_we, no wait    | image_width (index 0), image_height (1)
//
// One transaction accepted per cycle while the pipeline is ready, writes and
// probes alike; a probe passes the bank read at its acceptance edge, then the
// horizontal blend, then the vertical blend into the output register.
// The rate is set by the image store: four parity banks, each with one read
// port, serve the four neighbours of a probe in the same cycle.
// Reset clears only control state and sets both dimensions to 256, clamped to
// the store; the store is not cleared and needs no clearing pass.
// A stalled output holds only the stages behind it that are full; empty stages
// keep taking transactions.
module bilinear_pixel_sampler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bps_in_if.sink                        in_ch,
  bps_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [bps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bps_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int BCW   = (CW > 1) ? CW - 1 : 1;
  localparam int BRW   = (RW > 1) ? RW - 1 : 1;
  localparam int AW    = BCW + BRW;
  localparam int DEPTH = 2 ** AW;

  // Stored as last valid index: a dimension of 0 acts as 1, above the store
  // it acts as the store size.
  function automatic int last_of(input logic [bps_pkg::CFG_W-1:0] v, input int maxv);
    int d;
    d = int'(v);
    if (d < 1) begin
      return 0;
    end else if (d > maxv) begin
      return maxv - 1;
    end
    return d - 1;
  endfunction

  logic [CW-1:0]            col_last_r, col_last_nxt;
  logic [RW-1:0]            row_last_r, row_last_nxt;
  logic                     in_fire, probe_fire, write_fire, write_in_store;
  logic [1:0]               write_bank;
  logic [AW-1:0]            write_addr;
  logic [CW-1:0]            write_col;
  logic [RW-1:0]            write_row;
  logic [AW-1:0]            rd_addr [4];
  logic [bps_pkg::PIX_W-1:0] bank_data [4];
  bps_pkg::bank_sel_t       sel;
  logic [FRAC_BITS-1:0]     wr, wb;
  logic                     pipe_ready;

  // Configuration: take the register write and keep it as a clamped last index
  always_comb begin
    col_last_nxt = col_last_r;
    row_last_nxt = row_last_r;
    if (cfg_we) begin
      case (cfg_index)
        bps_pkg::REG_IMAGE_WIDTH:  col_last_nxt = CW'(last_of(cfg_wdata, MAX_WIDTH));
        bps_pkg::REG_IMAGE_HEIGHT: row_last_nxt = RW'(last_of(cfg_wdata, MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= CW'(last_of(bps_pkg::CFG_W'(256), MAX_WIDTH));
      row_last_r <= RW'(last_of(bps_pkg::CFG_W'(256), MAX_HEIGHT));
    end else begin
      col_last_r <= col_last_nxt;
      row_last_r <= row_last_nxt;
    end
  end

  // Input handshake
  assign in_ch.ready = pipe_ready;
  assign in_fire     = in_ch.valid && pipe_ready;
  assign probe_fire  = in_fire && (in_ch.operation == bps_pkg::OP_PROBE);
  assign write_fire  = in_fire && (in_ch.operation == bps_pkg::OP_WRITE);

  // Pixel write: drop writes outside the store, otherwise route by parity
  assign write_in_store = (int'(in_ch.write_column) < MAX_WIDTH) &&
                          (int'(in_ch.write_row) < MAX_HEIGHT);
  assign write_col  = CW'(in_ch.write_column);
  assign write_row  = RW'(in_ch.write_row);
  assign write_bank = {write_row[0], write_col[0]};
  assign write_addr = {BRW'(write_row >> 1), BCW'(write_col >> 1)};

  bps_addr_gen #(
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW),
    .RW        (RW),
    .AW        (AW)
  ) u_addr_gen (
    .probe_x  (in_ch.probe_x),
    .probe_y  (in_ch.probe_y),
    .col_last (col_last_r),
    .row_last (row_last_r),
    .rd_addr  (rd_addr),
    .sel      (sel),
    .wr       (wr),
    .wb       (wb)
  );

  // Four parity banks; a write and a later probe never meet in the same cycle
  for (genvar k = 0; k < 4; k++) begin : g_bank
    bps_ram #(
      .WIDTH (bps_pkg::PIX_W),
      .DEPTH (DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (write_fire && write_in_store && (write_bank == 2'(k))),
      .waddr (write_addr),
      .wdata (in_ch.write_value),
      .re    (probe_fire),
      .raddr (rd_addr[k]),
      .rdata (bank_data[k])
    );
  end

  bps_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .probe_fire (probe_fire),
    .sel        (sel),
    .wr         (wr),
    .wb         (wb),
    .bank_data  (bank_data),
    .in_ready   (pipe_ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_sample (out_ch.sample)
  );

  a_col_last_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    int'(col_last_r) <= MAX_WIDTH - 1)
    else $error("column limit beyond the image store");

  a_row_last_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    int'(row_last_r) <= MAX_HEIGHT - 1)
    else $error("row limit beyond the image store");

  a_write_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    write_fire |-> !probe_fire)
    else $error("pixel write also issued a bank read");

endmodule
